FILE: rtl/sdh_pkg.sv
// ----------------------------------------------------------------------------
// sdh_pkg
// Shared sizes, codes, types and helpers for the value and difference
// histogram block.
// ----------------------------------------------------------------------------
package sdh_pkg;

  // Histogram geometry and counter width
  localparam int DIGITAL_BINS = 4096;
  localparam int ANALOG_BINS  = 2048;
  localparam int COUNT_BITS   = 32;

  // Channel and table counts
  localparam int NUM_DIG    = 3;
  localparam int NUM_ANA    = 2;
  localparam int NUM_CHANS  = NUM_DIG + NUM_ANA;
  localparam int NUM_TABLES = 2 * NUM_CHANS;

  // Field widths of the words on the channels
  localparam int SAMPLE_W    = 14;
  localparam int SEQ_W       = 32;
  localparam int SEL_W       = 4;
  localparam int BIN_W       = 13;
  localparam int STATUS_W    = 3;
  localparam int OUT_COUNT_W = 32;

  // Table address widths
  localparam int DIG_VAL_AW = $clog2(DIGITAL_BINS);
  localparam int ANA_VAL_AW = $clog2(ANALOG_BINS);
  localparam int DIG_DLT_AW = $clog2(2 * DIGITAL_BINS);
  localparam int ANA_DLT_AW = $clog2(2 * ANALOG_BINS);

  // Clearing pass covers the deepest table
  localparam int CLEAR_AW = (DIG_DLT_AW > ANA_DLT_AW) ? DIG_DLT_AW : ANA_DLT_AW;
  // Common address width: wide enough for every table and for a read bin
  localparam int ADDR_W   = (CLEAR_AW > BIN_W) ? CLEAR_AW : BIN_W;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  // Request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_REJECT = 3'd0,
    STATUS_PRIMED = 3'd1,
    STATUS_VALUES = 3'd2,
    STATUS_BOTH   = 3'd3,
    STATUS_READ   = 3'd4
  } status_t;

  // Table codes: value tables in channel order, then difference tables
  localparam logic [SEL_W-1:0] TBL_DX_VAL = 4'd0;
  localparam logic [SEL_W-1:0] TBL_DY_VAL = 4'd1;
  localparam logic [SEL_W-1:0] TBL_DZ_VAL = 4'd2;
  localparam logic [SEL_W-1:0] TBL_AX_VAL = 4'd3;
  localparam logic [SEL_W-1:0] TBL_AY_VAL = 4'd4;
  localparam logic [SEL_W-1:0] TBL_DX_DLT = 4'd5;
  localparam logic [SEL_W-1:0] TBL_DY_DLT = 4'd6;
  localparam logic [SEL_W-1:0] TBL_DZ_DLT = 4'd7;
  localparam logic [SEL_W-1:0] TBL_AX_DLT = 4'd8;
  localparam logic [SEL_W-1:0] TBL_AY_DLT = 4'd9;

  // Input word as seen by the front end
  typedef struct packed {
    logic                                req_type;
    logic [SEQ_W-1:0]                    seq_num;
    logic [NUM_DIG-1:0][SAMPLE_W-1:0]    dig;
    logic [NUM_ANA-1:0][SAMPLE_W-1:0]    ana;
    logic [SEL_W-1:0]                    table_select;
    logic [BIN_W-1:0]                    bin_index;
  } in_word_t;

  // Per-table access request: read the bin, and write it back bumped
  typedef struct packed {
    logic  rd;
    logic  bump;
    addr_t addr;
  } bin_req_t;

  // Per-word result information carried beside the table accesses
  typedef struct packed {
    status_t          status;
    logic [SEL_W-1:0] sel;
    logic             hit;
  } word_info_t;

  // Number of bins of a table; zero for an unknown table
  function automatic int table_depth(input logic [SEL_W-1:0] sel);
    int depth;
    case (sel)
      TBL_DX_VAL, TBL_DY_VAL, TBL_DZ_VAL: depth = DIGITAL_BINS;
      TBL_AX_VAL, TBL_AY_VAL:             depth = ANALOG_BINS;
      TBL_DX_DLT, TBL_DY_DLT, TBL_DZ_DLT: depth = 2 * DIGITAL_BINS;
      TBL_AX_DLT, TBL_AY_DLT:             depth = 2 * ANALOG_BINS;
      default:                            depth = 0;
    endcase
    return depth;
  endfunction

endpackage

FILE: rtl/sdh_if.sv
// ----------------------------------------------------------------------------
// sdh_if
// Valid/ready channels of the histogram block: request words in, result
// words out.
// ----------------------------------------------------------------------------
interface sdh_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  req_type;
  logic [sdh_pkg::SEQ_W-1:0]             seq_num;
  logic signed [sdh_pkg::SAMPLE_W-1:0]   digital_x;
  logic signed [sdh_pkg::SAMPLE_W-1:0]   digital_y;
  logic signed [sdh_pkg::SAMPLE_W-1:0]   digital_z;
  logic signed [sdh_pkg::SAMPLE_W-1:0]   analog_x;
  logic signed [sdh_pkg::SAMPLE_W-1:0]   analog_y;
  logic [sdh_pkg::SEL_W-1:0]             table_select;
  logic [sdh_pkg::BIN_W-1:0]             bin_index;

  modport source (
    output valid, req_type, seq_num, digital_x, digital_y, digital_z,
           analog_x, analog_y, table_select, bin_index,
    input  ready
  );

  modport sink (
    input  valid, req_type, seq_num, digital_x, digital_y, digital_z,
           analog_x, analog_y, table_select, bin_index,
    output ready
  );
endinterface

interface sdh_out_if;
  logic                            valid;
  logic                            ready;
  logic [sdh_pkg::STATUS_W-1:0]    status;
  logic [sdh_pkg::OUT_COUNT_W-1:0] count_value;

  modport source (
    output valid, status, count_value,
    input  ready
  );

  modport sink (
    input  valid, status, count_value,
    output ready
  );
endinterface

FILE: rtl/sdh_ram.sv
// ----------------------------------------------------------------------------
// sdh_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds until the next read.
// ----------------------------------------------------------------------------
module sdh_ram #(
  parameter int AW = 10,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] q,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign q = rd_data_r;

endmodule

FILE: rtl/sdh_front.sv
// ----------------------------------------------------------------------------
// sdh_front
// Request decode: range check, previous-sample registers, bin address
// generation and per-table access requests.
// ----------------------------------------------------------------------------
module sdh_front (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          accept,
  input  sdh_pkg::in_word_t                             in_word,
  output sdh_pkg::bin_req_t [sdh_pkg::NUM_TABLES-1:0]   req,
  output sdh_pkg::word_info_t                           info
);

  localparam int DMSB = sdh_pkg::DIG_VAL_AW - 1;

  logic [sdh_pkg::NUM_DIG-1:0][sdh_pkg::DIG_VAL_AW-1:0] dig_v;
  logic [sdh_pkg::NUM_ANA-1:0][sdh_pkg::ANA_VAL_AW-1:0] ana_v;
  logic [sdh_pkg::NUM_DIG-1:0]                          dig_ok;
  logic [sdh_pkg::NUM_ANA-1:0]                          ana_ok;
  sdh_pkg::addr_t [sdh_pkg::NUM_CHANS-1:0]              val_addr;
  sdh_pkg::addr_t [sdh_pkg::NUM_CHANS-1:0]              dlt_addr;
  logic                                                 is_read;
  logic                                                 sample_ok;
  logic                                                 follows;
  logic                                                 bump_val;
  logic                                                 bump_dlt;
  logic                                                 hit;

  logic [sdh_pkg::SEQ_W-1:0]                            prev_seq_r;
  logic [sdh_pkg::NUM_DIG-1:0][sdh_pkg::DIG_VAL_AW-1:0] prev_dig_r;
  logic [sdh_pkg::NUM_ANA-1:0][sdh_pkg::ANA_VAL_AW-1:0] prev_ana_r;
  logic                                                 primed_r;

  // Check ranges and form value and difference bins per channel
  always_comb begin
    for (int i = 0; i < sdh_pkg::NUM_DIG; i++) begin
      dig_v[i]  = in_word.dig[i][DMSB:0];
      // In range when the upper bits are a plain sign extension
      dig_ok[i] = (in_word.dig[i][sdh_pkg::SAMPLE_W-1:DMSB] == '0) ||
                  (in_word.dig[i][sdh_pkg::SAMPLE_W-1:DMSB] == '1);
      // Offset by half the table: flip the sign bit
      val_addr[i] = sdh_pkg::ADDR_W'({~dig_v[i][DMSB], dig_v[i][DMSB-1:0]});
      dlt_addr[i] = sdh_pkg::ADDR_W'(sdh_pkg::DIG_DLT_AW'(
                      {dig_v[i][DMSB], dig_v[i]} -
                      {prev_dig_r[i][DMSB], prev_dig_r[i]} +
                      sdh_pkg::DIG_DLT_AW'(sdh_pkg::DIGITAL_BINS)));
    end
    for (int i = 0; i < sdh_pkg::NUM_ANA; i++) begin
      ana_v[i]  = in_word.ana[i][sdh_pkg::ANA_VAL_AW-1:0];
      ana_ok[i] = (in_word.ana[i][sdh_pkg::SAMPLE_W-1:sdh_pkg::ANA_VAL_AW] == '0);
      val_addr[sdh_pkg::NUM_DIG+i] = sdh_pkg::ADDR_W'(ana_v[i]);
      dlt_addr[sdh_pkg::NUM_DIG+i] = sdh_pkg::ADDR_W'(sdh_pkg::ANA_DLT_AW'(
                                       {1'b0, ana_v[i]} - {1'b0, prev_ana_r[i]} +
                                       sdh_pkg::ANA_DLT_AW'(sdh_pkg::ANALOG_BINS)));
    end
  end

  // Classify the word
  assign is_read   = (in_word.req_type == sdh_pkg::REQ_READ);
  assign sample_ok = (&dig_ok) && (&ana_ok);
  assign follows   = ((prev_seq_r + sdh_pkg::SEQ_W'(1)) == in_word.seq_num);
  assign bump_val  = !is_read && sample_ok && primed_r;
  assign bump_dlt  = bump_val && follows;
  assign hit       = is_read &&
                     (int'(in_word.bin_index) < sdh_pkg::table_depth(in_word.table_select));

  // Build per-table requests; table codes follow channel order
  always_comb begin
    for (int c = 0; c < sdh_pkg::NUM_CHANS; c++) begin
      req[c].addr = is_read ? sdh_pkg::ADDR_W'(in_word.bin_index) : val_addr[c];
      req[c].bump = bump_val;
      req[c].rd   = bump_val ||
                    (hit && (in_word.table_select == sdh_pkg::SEL_W'(c)));
      req[sdh_pkg::NUM_CHANS+c].addr = is_read ? sdh_pkg::ADDR_W'(in_word.bin_index)
                                               : dlt_addr[c];
      req[sdh_pkg::NUM_CHANS+c].bump = bump_dlt;
      req[sdh_pkg::NUM_CHANS+c].rd   = bump_dlt ||
                    (hit && (in_word.table_select == sdh_pkg::SEL_W'(sdh_pkg::NUM_CHANS + c)));
    end
  end

  // Result status and read selection
  always_comb begin
    info.sel = in_word.table_select;
    info.hit = hit;
    if (is_read) begin
      info.status = sdh_pkg::STATUS_READ;
    end else if (!sample_ok) begin
      info.status = sdh_pkg::STATUS_REJECT;
    end else if (!primed_r) begin
      info.status = sdh_pkg::STATUS_PRIMED;
    end else if (follows) begin
      info.status = sdh_pkg::STATUS_BOTH;
    end else begin
      info.status = sdh_pkg::STATUS_VALUES;
    end
  end

  // Priming flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
    end else if (accept && !is_read && sample_ok) begin
      primed_r <= 1'b1;
    end
  end

  // Hold the last accepted sample; read only once primed
  always_ff @(posedge clk) begin
    if (accept && !is_read && sample_ok) begin
      prev_seq_r <= in_word.seq_num;
      prev_dig_r <= dig_v;
      prev_ana_r <= ana_v;
    end
  end

endmodule

FILE: rtl/sdh_rmw.sv
// ----------------------------------------------------------------------------
// sdh_rmw
// Read-modify-write control of one histogram table: issues the read,
// bypasses the last write on an address match, saturates the increment
// and drives the write port, which the clearing pass also uses.
// ----------------------------------------------------------------------------
module sdh_rmw (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              advance,
  input  logic              clear,
  input  sdh_pkg::addr_t    clr_addr,
  input  sdh_pkg::bin_req_t req,
  input  sdh_pkg::count_t   ram_q,
  output logic              ram_re,
  output sdh_pkg::addr_t    ram_raddr,
  output logic              ram_we,
  output sdh_pkg::addr_t    ram_waddr,
  output sdh_pkg::count_t   ram_wdata,
  output sdh_pkg::count_t   count
);

  logic            s1_bump_r;
  sdh_pkg::addr_t  s1_addr_r;
  logic            lw_valid_r;
  sdh_pkg::addr_t  lw_addr_r;
  sdh_pkg::count_t lw_data_r;
  sdh_pkg::count_t bumped;
  logic            write_en;

  // Issue the read as the word is accepted
  assign ram_re    = accept && req.rd;
  assign ram_raddr = req.addr;

  // Bypass the write that landed on the same edge as this read
  assign count  = (lw_valid_r && (lw_addr_r == s1_addr_r)) ? lw_data_r : ram_q;
  assign bumped = (count == '1) ? count : count + sdh_pkg::COUNT_BITS'(1);

  // Write back on advance; the clearing pass takes the port while it runs
  assign write_en  = advance && s1_bump_r;
  assign ram_we    = clear || write_en;
  assign ram_waddr = clear ? clr_addr : s1_addr_r;
  assign ram_wdata = clear ? '0 : bumped;

  // Second stage request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_bump_r <= 1'b0;
    end else if (accept) begin
      s1_bump_r <= req.bump;
    end else if (advance) begin
      s1_bump_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r <= req.addr;
    end
  end

  // Last write tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (clear) begin
      lw_valid_r <= 1'b0;
    end else if (write_en) begin
      lw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      lw_addr_r <= s1_addr_r;
      lw_data_r <= bumped;
    end
  end

endmodule

FILE: rtl/sample_and_delta_histogram.sv
// ----------------------------------------------------------------------------
// sample_and_delta_histogram
// Value and difference histograms over a five-channel sensor sample stream,
// with single-bin read-back.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every address of the deepest
// table that zeroes all ten tables in parallel; in_chan.ready stays low
// until it ends. From then on it takes one word per cycle while the read
// stage is empty or advancing: each table is a RAM with a registered read,
// read when the word is accepted and written back with the saturated count
// as the word leaves the read stage, with a bypass of the last write so
// that back-to-back hits on the same bin count correctly. The result passes
// through the RAM read register, then the output register. A full output
// register stalls only the stage that holds the read data; the block still
// takes a new word while that stage is empty.
// ----------------------------------------------------------------------------
module sample_and_delta_histogram (
  input  logic      clk,
  input  logic      rst_n,
  sdh_in_if.sink    in_chan,
  sdh_out_if.source out_chan
);

  sdh_pkg::in_word_t                          in_word;
  sdh_pkg::bin_req_t [sdh_pkg::NUM_TABLES-1:0] req;
  sdh_pkg::word_info_t                        front_info;

  logic                  ram_re    [sdh_pkg::NUM_TABLES];
  sdh_pkg::addr_t        ram_raddr [sdh_pkg::NUM_TABLES];
  logic                  ram_we    [sdh_pkg::NUM_TABLES];
  sdh_pkg::addr_t        ram_waddr [sdh_pkg::NUM_TABLES];
  sdh_pkg::count_t       ram_wdata [sdh_pkg::NUM_TABLES];
  sdh_pkg::count_t       ram_q     [sdh_pkg::NUM_TABLES];
  sdh_pkg::count_t       cnt       [sdh_pkg::NUM_TABLES];

  logic                            clearing_r;
  logic [sdh_pkg::CLEAR_AW-1:0]    clr_addr_r;
  logic                            s1_valid_r;
  sdh_pkg::word_info_t             s1_info_r;
  logic                            out_valid_r;
  sdh_pkg::status_t                out_status_r;
  logic [sdh_pkg::OUT_COUNT_W-1:0] out_count_r;

  logic            in_ready;
  logic            accept;
  logic            advance;
  sdh_pkg::count_t sel_count;

  // Pack the input word
  assign in_word.req_type     = in_chan.req_type;
  assign in_word.seq_num      = in_chan.seq_num;
  assign in_word.dig[0]       = in_chan.digital_x;
  assign in_word.dig[1]       = in_chan.digital_y;
  assign in_word.dig[2]       = in_chan.digital_z;
  assign in_word.ana[0]       = in_chan.analog_x;
  assign in_word.ana[1]       = in_chan.analog_y;
  assign in_word.table_select = in_chan.table_select;
  assign in_word.bin_index    = in_chan.bin_index;

  // Handshake: the read stage advances when the output register frees up
  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready      = !clearing_r && (!s1_valid_r || advance);
  assign accept        = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  sdh_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_word (in_word),
    .req     (req),
    .info    (front_info)
  );

  // One RAM and one read-modify-write unit per table
  for (genvar t = 0; t < sdh_pkg::NUM_TABLES; t++) begin : g_table
    localparam int TAW = $clog2(sdh_pkg::table_depth(sdh_pkg::SEL_W'(t)));

    sdh_rmw u_rmw (
      .clk       (clk),
      .rst_n     (rst_n),
      .accept    (accept),
      .advance   (advance),
      .clear     (clearing_r),
      .clr_addr  (sdh_pkg::ADDR_W'(clr_addr_r)),
      .req       (req[t]),
      .ram_q     (ram_q[t]),
      .ram_re    (ram_re[t]),
      .ram_raddr (ram_raddr[t]),
      .ram_we    (ram_we[t]),
      .ram_waddr (ram_waddr[t]),
      .ram_wdata (ram_wdata[t]),
      .count     (cnt[t])
    );

    sdh_ram #(
      .AW (TAW),
      .DW (sdh_pkg::COUNT_BITS)
    ) u_ram (
      .clk   (clk),
      .re    (ram_re[t]),
      .raddr (ram_raddr[t][TAW-1:0]),
      .q     (ram_q[t]),
      .we    (ram_we[t]),
      .waddr (ram_waddr[t][TAW-1:0]),
      .wdata (ram_wdata[t])
    );
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + sdh_pkg::CLEAR_AW'(1);
      if (clr_addr_r == '1) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Read stage occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= front_info;
    end
  end

  // Select the count of the table being read
  always_comb begin
    sel_count = '0;
    for (int t = 0; t < sdh_pkg::NUM_TABLES; t++) begin
      if (s1_info_r.hit && (s1_info_r.sel == sdh_pkg::SEL_W'(t))) begin
        sel_count = cnt[t];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= s1_info_r.status;
      out_count_r  <= sdh_pkg::OUT_COUNT_W'(sel_count);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.count_value = out_count_r;

endmodule
